@@ sv/smej_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants for the sorted merge equi-join block.
// No dependencies; every other file of the block but smej_ram imports this package.
package smej_pkg;

  // Sizes of the B table and of the per-probe result limit.
  localparam int B_DEPTH     = 4096;
  localparam int B_AW        = $clog2(B_DEPTH);
  localparam int B_CW        = $clog2(B_DEPTH + 1);
  localparam int MAX_MATCHES = 64;
  localparam int M_CW        = $clog2(MAX_MATCHES + 1);

  // Field widths of the items.
  localparam int KEY_W = 64;
  localparam int TAG_W = 32;
  localparam int ID_W  = 32;
  localparam int ENT_W = KEY_W + ID_W;

  // Depth of the command queue between front and back.
  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = $clog2(Q_DEPTH);
  localparam int Q_CW    = $clog2(Q_DEPTH + 1);

  // Function codes carried in the input tuser.
  localparam logic [1:0] FN_LOAD    = 2'd0;
  localparam logic [1:0] FN_PROBE   = 2'd1;
  localparam logic [1:0] FN_RESTART = 2'd2;

  // One queued command.
  typedef struct packed {
    logic [1:0]       func;
    logic [KEY_W-1:0] key;
    logic [TAG_W-1:0] a_tag;
    logic [ID_W-1:0]  b_ident;
  } cmd_t;

endpackage

@@ sv/sorted_merge_equi_join.sv @@
`timescale 1ns / 1ps
// Sorted merge equi-join between a loaded B table and a stream of A probes.
// Channels: the in_ stream carries load, probe and restart items, selected
// by in_tuser; the out_ stream carries one item per match, in B order, with
// tlast on the final match of a probe and tuser set there when further
// equal B entries were dropped beyond the per-probe limit.
// Items enter a four-deep command queue, so in_tready stays high while the
// queue has room, even when the result side is stalled.
// Sequence: a load or restart is done in the idle state of the back end. A
// probe is popped in the idle state, steps over each B entry skipped or
// matched and then ends; the sequencer reads one table entry per cycle,
// unless a stalled result holds it, through the single read port of the
// B table. A probe without a match emits nothing.
// When out_tready is low the result register holds its item and a probe in
// the back end waits; the queue keeps taking items until it is full.
// Reset empties the queue and the B table and sets the scan to the first
// entry. It is synchronous to clk; the table itself is not cleared.
// Depends on smej_pkg, smej_front, smej_back and smej_ram.
module sorted_merge_equi_join
  import smej_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [127:0] in_tdata,   // key[63:0], a_tag[95:64], b_ident[127:96]
  input  logic [1:0]   in_tuser,   // func[1:0]
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [63:0]  out_tdata,  // out_a_tag[31:0], out_b_ident[63:32]
  output logic         out_tlast,
  output logic         out_tuser   // overflow[0]
);

  logic q_vld;
  cmd_t q_cmd;
  logic q_pop;

  // Accept and classify items.
  smej_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_vld     (q_vld),
    .q_cmd     (q_cmd),
    .q_pop     (q_pop)
  );

  // Execute commands and produce results.
  smej_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_vld      (q_vld),
    .q_cmd      (q_cmd),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

endmodule

@@ sv/smej_ram.sv @@
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module smej_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

@@ sv/smej_front.sv @@
`timescale 1ns / 1ps
// Front end: accepts input items, drops unused function codes and queues
// the rest for the back end. Depends on smej_pkg.
module smej_front
  import smej_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [127:0] in_tdata,
  input  logic [1:0]   in_tuser,
  output logic         q_vld,
  output cmd_t         q_cmd,
  input  logic         q_pop
);

  cmd_t            q_mem_r [Q_DEPTH];
  logic [Q_AW-1:0] wr_ptr_r;
  logic [Q_AW-1:0] rd_ptr_r;
  logic [Q_CW-1:0] cnt_r;
  logic            push;
  cmd_t            in_cmd;

  // Unpack the item; an unused code is taken but never queued.
  always_comb begin
    in_cmd.func    = in_tuser;
    in_cmd.key     = in_tdata[KEY_W-1:0];
    in_cmd.a_tag   = in_tdata[KEY_W+TAG_W-1:KEY_W];
    in_cmd.b_ident = in_tdata[KEY_W+TAG_W+ID_W-1:KEY_W+TAG_W];
  end

  assign in_tready = (cnt_r != Q_CW'(Q_DEPTH));
  assign push = in_tvalid && in_tready &&
                ((in_tuser == FN_LOAD) || (in_tuser == FN_PROBE) ||
                 (in_tuser == FN_RESTART));
  assign q_vld = (cnt_r != '0);
  assign q_cmd = q_mem_r[rd_ptr_r];

  // Queue storage.
  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r] <= in_cmd;
    end
  end

  // Queue pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (q_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (push && !q_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (!push && q_pop) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

@@ sv/smej_back.sv @@
`timescale 1ns / 1ps
// Back end: executes queued loads, restarts and probes against the B table
// and drives the result register. Depends on smej_pkg and smej_ram.
module smej_back
  import smej_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        q_vld,
  input  cmd_t        q_cmd,
  output logic        q_pop,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,
  output logic        out_tlast,
  output logic        out_tuser
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SKIP = 2'd1;
  localparam logic [1:0] S_RUN  = 2'd2;

  logic [1:0]       state_r,   state_nxt;
  logic [B_CW-1:0]  fill_r,    fill_nxt;
  logic [B_CW-1:0]  scan_r,    scan_nxt;
  logic [B_CW-1:0]  pos_r,     pos_nxt;
  logic [M_CW-1:0]  cnt_r,     cnt_nxt;
  logic [KEY_W-1:0] key_r,     key_nxt;
  logic [TAG_W-1:0] tag_r,     tag_nxt;
  logic [ID_W-1:0]  pend_r,    pend_nxt;
  logic             out_vld_r, out_vld_nxt;
  logic [TAG_W-1:0] out_tag_r, out_tag_nxt;
  logic [ID_W-1:0]  out_id_r,  out_id_nxt;
  logic             out_last_r, out_last_nxt;
  logic             out_ovf_r, out_ovf_nxt;

  logic             ram_we;
  logic [ENT_W-1:0] rd_data;
  logic [KEY_W-1:0] rd_key;
  logic [ID_W-1:0]  rd_id;
  logic             in_range;
  logic             eq;
  logic             can_emit;

  // B table: key in the low bits, identifier above it.
  smej_ram #(
    .WIDTH (ENT_W),
    .DEPTH (B_DEPTH)
  ) u_table (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (fill_r[B_AW-1:0]),
    .wr_data ({q_cmd.b_ident, q_cmd.key}),
    .rd_addr (pos_nxt[B_AW-1:0]),
    .rd_data (rd_data)
  );

  assign rd_key   = rd_data[KEY_W-1:0];
  assign rd_id    = rd_data[ENT_W-1:KEY_W];
  assign in_range = (pos_r < fill_r);
  assign eq       = in_range && (rd_key == key_r);
  assign can_emit = !out_vld_r || out_tready;

  // Sequencer: in the skip and run states the read data holds the entry at pos_r.
  always_comb begin
    state_nxt    = state_r;
    fill_nxt     = fill_r;
    scan_nxt     = scan_r;
    pos_nxt      = pos_r;
    cnt_nxt      = cnt_r;
    key_nxt      = key_r;
    tag_nxt      = tag_r;
    pend_nxt     = pend_r;
    q_pop        = 1'b0;
    ram_we       = 1'b0;
    out_vld_nxt  = out_vld_r && !out_tready;
    out_tag_nxt  = out_tag_r;
    out_id_nxt   = out_id_r;
    out_last_nxt = out_last_r;
    out_ovf_nxt  = out_ovf_r;
    unique case (state_r)
      S_IDLE: begin
        if (q_vld) begin
          q_pop = 1'b1;
          case (q_cmd.func)
            FN_LOAD: begin
              if (fill_r < B_CW'(B_DEPTH)) begin
                ram_we   = 1'b1;
                fill_nxt = fill_r + 1'b1;
              end
            end
            FN_RESTART: begin
              scan_nxt = '0;
            end
            FN_PROBE: begin
              key_nxt   = q_cmd.key;
              tag_nxt   = q_cmd.a_tag;
              pos_nxt   = scan_r;
              state_nxt = S_SKIP;
            end
            default: begin
            end
          endcase
        end
      end
      S_SKIP: begin
        // Step past smaller keys; the scan start follows.
        if (in_range && (rd_key < key_r)) begin
          pos_nxt  = pos_r + 1'b1;
          scan_nxt = pos_r + 1'b1;
        end else if (eq) begin
          pend_nxt  = rd_id;
          cnt_nxt   = M_CW'(1);
          pos_nxt   = pos_r + 1'b1;
          state_nxt = S_RUN;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_RUN: begin
        // Emit the held match once the next entry tells whether it is last.
        if (can_emit) begin
          out_vld_nxt = 1'b1;
          out_tag_nxt = tag_r;
          out_id_nxt  = pend_r;
          if (!eq || (cnt_r == M_CW'(MAX_MATCHES))) begin
            out_last_nxt = 1'b1;
            out_ovf_nxt  = eq;
            state_nxt    = S_IDLE;
          end else begin
            out_last_nxt = 1'b0;
            out_ovf_nxt  = 1'b0;
            pend_nxt     = rd_id;
            cnt_nxt      = cnt_r + 1'b1;
            pos_nxt      = pos_r + 1'b1;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      fill_r    <= '0;
      scan_r    <= '0;
      pos_r     <= '0;
      cnt_r     <= '0;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      fill_r    <= fill_nxt;
      scan_r    <= scan_nxt;
      pos_r     <= pos_nxt;
      cnt_r     <= cnt_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    key_r      <= key_nxt;
    tag_r      <= tag_nxt;
    pend_r     <= pend_nxt;
    out_tag_r  <= out_tag_nxt;
    out_id_r   <= out_id_nxt;
    out_last_r <= out_last_nxt;
    out_ovf_r  <= out_ovf_nxt;
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {out_id_r, out_tag_r};
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_ovf_r;

endmodule

@@ verif/sorted_merge_equi_join_tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for sorted_merge_equi_join: B loads, A probes and scan restarts
// go in on the input stream, and every match result is compared against a local join tracker.
// Depends on smej_pkg and the sorted_merge_equi_join RTL.
import smej_pkg::*;

// The selector value that has no function; the block drops such items.
localparam logic [1:0] FN_SPARE = 2'd3;

// One expected match result.
typedef struct packed {
  logic [TAG_W-1:0] a_tag;
  logic [ID_W-1:0]  b_ident;
  logic             last_match;
  logic             overflow;
} match_t;

// Keeps its own copy of the B table and the scan pointer, and queues the
// matches that each accepted probe must produce.
class match_tracker;
  logic [KEY_W-1:0] b_keys [B_DEPTH];
  logic [ID_W-1:0]  b_ids [B_DEPTH];
  int               b_fill;
  int               scan_pos;
  int               errors;
  match_t           pending[$];

  function void take_item(logic [1:0] func, logic [KEY_W-1:0] key,
                          logic [TAG_W-1:0] tag, logic [ID_W-1:0] ident);
    match_t run[$];
    match_t m;
    int     pos;
    case (func)
      FN_LOAD: begin
        // A load into a full table is dropped.
        if (b_fill < B_DEPTH) begin
          b_keys[b_fill] = key;
          b_ids[b_fill]  = ident;
          b_fill++;
        end
      end
      FN_RESTART: scan_pos = 0;
      FN_PROBE: begin
        // Skip the smaller keys, then collect the equal run up to the limit.
        while (scan_pos < b_fill && b_keys[scan_pos] < key) scan_pos++;
        pos = scan_pos;
        while (pos < b_fill && b_keys[pos] == key && run.size() < MAX_MATCHES) begin
          m.a_tag      = tag;
          m.b_ident    = b_ids[pos];
          m.last_match = 1'b0;
          m.overflow   = 1'b0;
          run.push_back(m);
          pos++;
        end
        // The final match carries tlast, and the overflow flag if equal entries remain.
        if (run.size() != 0) begin
          run[run.size()-1].last_match = 1'b1;
          run[run.size()-1].overflow   = (pos < b_fill && b_keys[pos] == key);
          foreach (run[i]) pending.push_back(run[i]);
        end
      end
      default: ;
    endcase
  endfunction

  function void check_match(logic [TAG_W-1:0] a_tag, logic [ID_W-1:0] b_ident,
                            logic last_match, logic overflow);
    match_t want;
    if (pending.size() == 0) begin
      $error("unexpected result: out_a_tag %h out_b_ident %h", a_tag, b_ident);
      errors++;
      return;
    end
    want = pending.pop_front();
    if (a_tag !== want.a_tag) begin
      $error("out_a_tag: expected %h, actual %h", want.a_tag, a_tag);
      errors++;
    end
    if (b_ident !== want.b_ident) begin
      $error("out_b_ident: expected %h, actual %h", want.b_ident, b_ident);
      errors++;
    end
    if (last_match !== want.last_match) begin
      $error("last_match: expected %b, actual %b", want.last_match, last_match);
      errors++;
    end
    if (overflow !== want.overflow) begin
      $error("overflow: expected %b, actual %b", want.overflow, overflow);
      errors++;
    end
  endfunction
endclass

module sorted_merge_equi_join_tb;
  localparam int HANG_LIMIT   = 20000;
  localparam int DRAIN_CYCLES = 100;
  localparam int RANDOM_ITEMS = 140;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [127:0] in_tdata;
  logic [1:0]   in_tuser;
  logic         out_tvalid;
  logic         out_tready;
  logic [63:0]  out_tdata;
  logic         out_tlast;
  logic         out_tuser;

  bit           idle_on;
  int           quiet_cycles;
  logic [63:0]  loaded_keys[$];
  match_tracker tracker = new();

  sorted_merge_equi_join DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Watch both channels at the rising edge.
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready)
      tracker.take_item(in_tuser, in_tdata[63:0], in_tdata[95:64], in_tdata[127:96]);
    if (rst_n && out_tvalid && out_tready)
      tracker.check_match(out_tdata[31:0], out_tdata[63:32], out_tlast, out_tuser);
  end

  // Give up when neither channel has moved an item for too long.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= HANG_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Result side: ready with random stall bursts while idling is enabled.
  initial begin
    out_tready = 1'b0;
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      if (idle_on && $urandom_range(0, 5) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 8)) @(negedge clk);
      end
      out_tready <= 1'b1;
      @(negedge clk);
    end
  end

  // Offer one item from a falling edge and return at the falling edge after it is taken.
  task automatic push_item(input logic [1:0] func, input logic [63:0] key,
                           input logic [31:0] tag, input logic [31:0] ident);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= func;
    in_tdata  <= {ident, tag, key};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic load_entry(input logic [63:0] key);
    push_item(FN_LOAD, key, $urandom, $urandom);
    loaded_keys.push_back(key);
  endtask

  initial begin
    logic [63:0] b_key;
    logic [63:0] probe_key;
    logic [63:0] run_key;
    int          gen_pos;
    int          taken;
    int          pick;

    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = FN_LOAD;
    idle_on   = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Probes on an empty table, and an item with the spare selector.
    push_item(FN_PROBE, 64'd0, 32'hFFFF_FFFF, 32'h0);
    push_item(FN_PROBE, '1, 32'h0, 32'hFFFF_FFFF);
    push_item(FN_SPARE, '1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);

    // A small table with duplicate keys and one key out of order.
    push_item(FN_LOAD, 64'd0, 32'hFFFF_FFFF, 32'h0);
    push_item(FN_LOAD, 64'd0, 32'h0, 32'hFFFF_FFFF);
    loaded_keys.push_back(64'd0);
    loaded_keys.push_back(64'd0);
    load_entry(64'd7);
    load_entry(64'd7);
    load_entry(64'd7);
    load_entry(64'd12);
    load_entry(64'd9);
    load_entry(64'd12);
    load_entry(64'd20);

    // Matches, a repeated A key, a miss, a run cut short by the unsorted entry,
    // descending probes and a probe past every entry.
    push_item(FN_RESTART, '1, $urandom, $urandom);
    push_item(FN_PROBE, 64'd0, 32'h0, $urandom);
    push_item(FN_PROBE, 64'd0, 32'hFFFF_FFFF, $urandom);
    push_item(FN_PROBE, 64'd5, $urandom, $urandom);
    push_item(FN_PROBE, 64'd7, $urandom, $urandom);
    push_item(FN_PROBE, 64'd12, $urandom, $urandom);
    push_item(FN_PROBE, 64'd10, $urandom, $urandom);
    push_item(FN_PROBE, 64'd9, $urandom, $urandom);
    push_item(FN_PROBE, '1, $urandom, $urandom);

    // A load behind the scan pointer, then a fresh scan.
    load_entry(64'd25);
    push_item(FN_PROBE, 64'd25, $urandom, $urandom);
    push_item(FN_RESTART, 64'd0, $urandom, $urandom);
    push_item(FN_PROBE, 64'd12, $urandom, $urandom);
    push_item(FN_SPARE, 64'd12, $urandom, $urandom);

    // Random episodes: append sorted B entries, then probe with mostly ascending A keys.
    idle_on   = 1'b1;
    b_key     = 64'd1000;
    probe_key = '0;
    gen_pos   = 0;
    taken     = 0;
    while (taken < RANDOM_ITEMS) begin
      repeat ($urandom_range(2, 8)) begin
        if ($urandom_range(0, 2) != 0)
          b_key = b_key + (64'($urandom_range(1, 1000)) << $urandom_range(0, 24));
        load_entry(b_key);
        taken++;
      end
      if ($urandom_range(0, 4) != 0) begin
        push_item(FN_RESTART, {$urandom, $urandom}, $urandom, $urandom);
        taken++;
        gen_pos   = 0;
        probe_key = '0;
      end
      repeat ($urandom_range(2, 10)) begin
        pick = $urandom_range(0, 9);
        if (pick < 5) begin
          // Hit a loaded key at or a little beyond the current one.
          while (gen_pos < loaded_keys.size() - 1 && loaded_keys[gen_pos] < probe_key)
            gen_pos++;
          gen_pos = gen_pos + $urandom_range(0, 2);
          if (gen_pos >= loaded_keys.size()) gen_pos = loaded_keys.size() - 1;
          if (loaded_keys[gen_pos] > probe_key) probe_key = loaded_keys[gen_pos];
        end else if (pick < 9 && pick >= 7) begin
          probe_key = probe_key + 1;
        end else if (pick == 9) begin
          // Out of order: usually below the previous A key.
          probe_key = {$urandom, $urandom} >> $urandom_range(20, 63);
        end
        push_item(FN_PROBE, probe_key, $urandom, $urandom);
        taken++;
        if ($urandom_range(0, 9) == 0)
          push_item(FN_SPARE, {$urandom, $urandom}, $urandom, $urandom);
      end
    end

    // Full-speed tail: an equal run at the limit and one beyond it.
    idle_on = 1'b0;
    run_key = b_key + 5;
    repeat (MAX_MATCHES) load_entry(run_key);
    repeat (MAX_MATCHES + 6) load_entry(run_key + 3);
    push_item(FN_RESTART, {$urandom, $urandom}, $urandom, $urandom);
    push_item(FN_PROBE, run_key, $urandom, $urandom);
    push_item(FN_PROBE, run_key, $urandom, $urandom);
    push_item(FN_PROBE, run_key + 3, $urandom, $urandom);
    push_item(FN_PROBE, run_key + 4, $urandom, $urandom);
    push_item(FN_PROBE, '1, $urandom, $urandom);
    in_tvalid <= 1'b0;

    // Drain, then keep watching for anything stray.
    while (tracker.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (tracker.pending.size() != 0) begin
      $error("%0d expected results never arrived", tracker.pending.size());
      tracker.errors++;
    end
    if (tracker.errors == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end
endmodule
